// ----- rtl/gvi_pkg.sv -----
package gvi_pkg;

	// build-time settings
	localparam int DAC_BITS = 16;
	localparam int MAX_STEPS = 65536;

	// derived widths
	localparam int STEPS_W = $clog2(MAX_STEPS + 1);
	localparam int DIFF_W = 33;
	localparam int ACC_W = 66;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 34;
	localparam int CHUNK_W = 17;
	localparam int PROD_W = MUL_A_W + CHUNK_W;
	localparam int DEN_W = 32 + STEPS_W;
	localparam int CS_W = (DEN_W + 1 > 37) ? DEN_W + 1 : 37;
	localparam int CNT_W = 6;
	localparam int DAC_MAX = (1 << DAC_BITS) - 1;

	localparam logic [31:0] FEED_FLOOR = 32'd393216;
	localparam logic [MUL_B_W-1:0] US_PER_MIN = MUL_B_W'(60000000);

	// sequencer count loads (count down to zero inclusive)
	localparam logic [CNT_W-1:0] CNT_MUL = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_ROOT = CNT_W'(32);
	localparam logic [CNT_W-1:0] CNT_DIV = CNT_W'(32);
	localparam logic [CNT_W-1:0] CNT_DLY = CNT_W'(31);

	// item actions
	localparam logic [1:0] ACT_RAPID = 2'd0;
	localparam logic [1:0] ACT_FEED = 2'd1;
	localparam logic [1:0] ACT_ORIGIN = 2'd2;
	localparam logic [1:0] ACT_TICK = 2'd3;

	// result status codes
	localparam logic [1:0] ST_MID = 2'd0;
	localparam logic [1:0] ST_FINAL = 2'd1;
	localparam logic [1:0] ST_BUSY = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_X_MIN = 3'd0;
	localparam logic [2:0] CFG_X_MAX = 3'd1;
	localparam logic [2:0] CFG_Y_MIN = 3'd2;
	localparam logic [2:0] CFG_Y_MAX = 3'd3;
	localparam logic [2:0] CFG_STEP_LEN = 3'd4;
	localparam logic [2:0] CFG_SCALE_X = 3'd5;
	localparam logic [2:0] CFG_SCALE_Y = 3'd6;
	localparam logic [2:0] CFG_RAPID_FEED = 3'd7;

	typedef struct packed {
		logic [1:0] action;
		logic signed [31:0] dest_x;
		logic signed [31:0] dest_y;
		logic [31:0] move_feed;
	} cmd_t;

	typedef struct packed {
		logic [15:0] dac_x;
		logic [15:0] dac_y;
		logic [1:0] status;
		logic busy_res;
	} pt_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_DELTA, S_SQX, S_SQY, S_SQRT, S_CHK, S_DSTEP, S_SAT,
		S_DINCX, S_FIXX, S_DINCY, S_FIXY, S_NUM, S_DEN, S_DSAT, S_DDLY, S_ARM,
		S_CVX, S_CVY, S_EMIT
	} gvi_state_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] mul_a;
		logic [CHUNK_W-1:0] mul_b;
		logic [CS_W-1:0] cs_x;
		logic [CS_W-1:0] cs_y;
	} alu_req_t;

	typedef struct packed {
		logic [PROD_W-1:0] mul_p;
		logic [CS_W-1:0] cs_diff;
		logic cs_ge;
	} alu_rsp_t;

	// Q32.32 product to dac code, round half up, clamp high
	function automatic logic [15:0] dac_round(input logic [ACC_W-1:0] p);
		logic [ACC_W-33:0] whole;
		whole = p[ACC_W-1:32];
		if (whole >= (ACC_W-32)'(DAC_MAX)) begin
			return 16'(DAC_MAX);
		end
		return 16'(p[32 +: DAC_BITS]) + 16'(p[31]);
	endfunction

endpackage

// ----- rtl/gvi_alu.sv -----
module gvi_alu (
	input gvi_pkg::alu_req_t req,
	output gvi_pkg::alu_rsp_t rsp
);
	import gvi_pkg::*;

	logic [CS_W:0] sub;

	always_comb begin
		// one 34x17 partial product per cycle
		rsp.mul_p = PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
		// shared compare-subtract for root and division steps
		sub = {1'b0, req.cs_x} - {1'b0, req.cs_y};
		rsp.cs_ge = !sub[CS_W];
		rsp.cs_diff = sub[CS_W-1:0];
	end

endmodule

// ----- rtl/galvo_linear_move_interpolator.sv -----
// XY galvo line interpolator. Each item is a rapid move, a feed move, a set-origin
// or a one microsecond tick; positions are signed Q16.16 mm. A move clamps its
// target to the axis limits, takes the floored integer root of dx*dx+dy*dy and
// either jumps (shorter than step_len) or splits the line into
// floor(dist/step_len) steps, at most MAX_STEPS, spaced by
// dist*60e6/(feed*steps) ticks. The first point leaves at once, later points
// on tick expiry, then the exact target. Every point goes out as rounded,
// clamped dac codes. The setup time of a move is set by the one shared
// compare-subtract unit, which takes the square root and four divisions one
// bit per cycle, and by the 34x17 multiplier that forms each product from two
// partial products on the 17-bit halves of one operand, low half first. The
// block takes no item while it works on one; a finished point waits in the
// output register, so the next item can be taken before it is collected.
// Moves that arrive while a line is running are answered with a busy status
// and the current position.
module galvo_linear_move_interpolator (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input gvi_pkg::cmd_t cmd,
	output logic pt_valid,
	input logic pt_stall,
	output gvi_pkg::pt_t pt,
	input logic cfg_we,
	input logic [2:0] cfg_idx,
	input logic [31:0] cfg_wdata
);
	import gvi_pkg::*;

	// configuration
	logic signed [31:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [31:0] step_len_q, scale_x_q, scale_y_q, rapid_feed_q;

	// architectural motion state
	logic signed [31:0] pos_x_q, pos_y_q, goal_x_q, goal_y_q;
	logic signed [DIFF_W-1:0] inc_x_q, inc_y_q;
	logic [STEPS_W-1:0] steps_left_q;
	logic [31:0] delay_reload_q, delay_count_q;
	logic moving_q;

	// sequencer and working registers
	gvi_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	cmd_t cmd_q;
	logic [ACC_W-1:0] acc_q;
	logic [CS_W-1:0] rem_q;
	logic [DIFF_W-1:0] quo_q;
	logic [DIFF_W-1:0] ax_q, ay_q, dist_q;
	logic sx_q, sy_q;
	logic [31:0] feed_q;
	logic [STEPS_W-1:0] steps_q;
	logic dly_sat_q;
	logic [1:0] st_q;
	logic busy_q;
	logic [15:0] dac_x_q;
	pt_t pt_q;
	logic pt_valid_q;

	// combinational helpers
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic pt_load;
	logic hi_ph;
	logic [MUL_B_W-1:0] mul_b_full;
	logic [ACC_W-1:0] prod_ext, prod_sh, acc_base, mac;
	logic [31:0] sl_eff, feed_sel, feed_c, dly_c;
	logic signed [31:0] gx_c, gy_c;
	logic signed [DIFF_W-1:0] dx_c, dy_c;
	logic [CS_W-1:0] div_x, div_y, step_rem;
	logic [DEN_W-1:0] den;

	gvi_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= 32'sh7fffffff;
			y_min_q <= '0;
			y_max_q <= 32'sh7fffffff;
			step_len_q <= 32'd6554;
			scale_x_q <= 32'd65536;
			scale_y_q <= 32'd65536;
			rapid_feed_q <= 32'd393216000;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_X_MIN: x_min_q <= cfg_wdata;
				CFG_X_MAX: x_max_q <= cfg_wdata;
				CFG_Y_MIN: y_min_q <= cfg_wdata;
				CFG_Y_MAX: y_max_q <= cfg_wdata;
				CFG_STEP_LEN: step_len_q <= cfg_wdata;
				CFG_SCALE_X: scale_x_q <= cfg_wdata;
				CFG_SCALE_Y: scale_y_q <= cfg_wdata;
				CFG_RAPID_FEED: rapid_feed_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// target clamp: below min wins over above max
	always_comb begin
		if (cmd_q.dest_x < x_min_q) begin
			gx_c = x_min_q;
		end else if (cmd_q.dest_x > x_max_q) begin
			gx_c = x_max_q;
		end else begin
			gx_c = cmd_q.dest_x;
		end
		if (cmd_q.dest_y < y_min_q) begin
			gy_c = y_min_q;
		end else if (cmd_q.dest_y > y_max_q) begin
			gy_c = y_max_q;
		end else begin
			gy_c = cmd_q.dest_y;
		end
	end

	assign feed_sel = (cmd_q.action == ACT_RAPID) ? rapid_feed_q : cmd_q.move_feed;
	assign feed_c = (feed_sel < FEED_FLOOR) ? FEED_FLOOR : feed_sel;
	assign sl_eff = (step_len_q == '0) ? 32'd1 : step_len_q;
	assign dx_c = {goal_x_q[31], goal_x_q} - {pos_x_q[31], pos_x_q};
	assign dy_c = {goal_y_q[31], goal_y_q} - {pos_y_q[31], pos_y_q};
	assign den = acc_q[DEN_W-1:0];

	// delay: saturated, or quotient with a floor of one tick
	always_comb begin
		if (dly_sat_q) begin
			dly_c = '1;
		end else if (quo_q[31:0] == '0) begin
			dly_c = 32'd1;
		end else begin
			dly_c = quo_q[31:0];
		end
	end

	// multiply-accumulate: low chunk first, then high chunk shifted
	assign hi_ph = (cnt_q == '0);
	assign prod_ext = ACC_W'(alu_rsp.mul_p);
	assign prod_sh = hi_ph ? (prod_ext << CHUNK_W) : prod_ext;
	assign acc_base = (state_q == S_SQY || hi_ph) ? acc_q : '0;
	assign mac = acc_base + prod_sh;

	// restoring step: keep the difference when it does not go negative
	assign div_x = {rem_q[CS_W-2:0], quo_q[DIFF_W-1]};
	assign step_rem = alu_rsp.cs_ge ? alu_rsp.cs_diff : alu_req.cs_x;

	always_comb begin
		case (state_q)
			S_DSTEP: div_y = CS_W'(sl_eff);
			S_DINCX: div_y = CS_W'(steps_q);
			S_DINCY: div_y = CS_W'(steps_q);
			default: div_y = CS_W'(den);
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_DEC;
			end
			S_DEC: begin
				case (cmd_q.action)
					ACT_ORIGIN: state_d = S_CVX;
					ACT_TICK: begin
						if (!moving_q || delay_count_q > 32'd1) begin
							state_d = S_IDLE;
						end else begin
							state_d = S_CVX;
						end
					end
					default: state_d = moving_q ? S_CVX : S_DELTA;
				endcase
			end
			S_DELTA: state_d = S_SQX;
			S_SQX: if (cnt_q == '0) state_d = S_SQY;
			S_SQY: if (cnt_q == '0) state_d = S_SQRT;
			S_SQRT: if (cnt_q == '0) state_d = S_CHK;
			S_CHK: state_d = alu_rsp.cs_ge ? S_DSTEP : S_CVX;
			S_DSTEP: if (cnt_q == '0) state_d = S_SAT;
			S_SAT: state_d = S_DINCX;
			S_DINCX: if (cnt_q == '0) state_d = S_FIXX;
			S_FIXX: state_d = S_DINCY;
			S_DINCY: if (cnt_q == '0) state_d = S_FIXY;
			S_FIXY: state_d = S_NUM;
			S_NUM: if (cnt_q == '0) state_d = S_DEN;
			S_DEN: if (cnt_q == '0) state_d = S_DSAT;
			S_DSAT: state_d = alu_rsp.cs_ge ? S_ARM : S_DDLY;
			S_DDLY: if (cnt_q == '0) state_d = S_ARM;
			S_ARM: state_d = S_CVX;
			S_CVX: if (cnt_q == '0) state_d = S_CVY;
			S_CVY: if (cnt_q == '0) state_d = S_EMIT;
			S_EMIT: if (pt_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: handshake and shared unit operands
	always_comb begin
		cmd_stall = (state_q != S_IDLE);
		pt_load = (state_q == S_EMIT) && (!pt_valid_q || !pt_stall);
		alu_req = '0;
		mul_b_full = '0;
		case (state_q)
			S_SQX: begin
				alu_req.mul_a = MUL_A_W'(ax_q);
				mul_b_full = MUL_B_W'(ax_q);
			end
			S_SQY: begin
				alu_req.mul_a = MUL_A_W'(ay_q);
				mul_b_full = MUL_B_W'(ay_q);
			end
			S_NUM: begin
				alu_req.mul_a = MUL_A_W'(dist_q);
				mul_b_full = US_PER_MIN;
			end
			S_DEN: begin
				alu_req.mul_a = MUL_A_W'(feed_q);
				mul_b_full = MUL_B_W'(steps_q);
			end
			// negative positions give a zero product and so code zero
			S_CVX: begin
				alu_req.mul_a = MUL_A_W'(scale_x_q);
				mul_b_full = pos_x_q[31] ? '0 : MUL_B_W'(pos_x_q[30:0]);
			end
			S_CVY: begin
				alu_req.mul_a = MUL_A_W'(scale_y_q);
				mul_b_full = pos_y_q[31] ? '0 : MUL_B_W'(pos_y_q[30:0]);
			end
			S_SQRT: begin
				alu_req.cs_x = CS_W'({rem_q[34:0], acc_q[ACC_W-1:ACC_W-2]});
				alu_req.cs_y = CS_W'({quo_q, 2'b01});
			end
			S_CHK: begin
				alu_req.cs_x = CS_W'(quo_q);
				alu_req.cs_y = CS_W'(sl_eff);
			end
			S_DSTEP, S_DINCX, S_DINCY, S_DDLY: begin
				alu_req.cs_x = div_x;
				alu_req.cs_y = div_y;
			end
			S_DSAT: begin
				alu_req.cs_x = rem_q;
				alu_req.cs_y = CS_W'(den);
			end
			default: ;
		endcase
		alu_req.mul_b = hi_ph ? mul_b_full[MUL_B_W-1:CHUNK_W] : mul_b_full[CHUNK_W-1:0];
	end

	// control and motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			inc_x_q <= '0;
			inc_y_q <= '0;
			steps_left_q <= '0;
			delay_reload_q <= '0;
			delay_count_q <= '0;
			moving_q <= 1'b0;
			pt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			if (pt_load) begin
				pt_valid_q <= 1'b1;
			end else if (!pt_stall) begin
				pt_valid_q <= 1'b0;
			end
			case (state_q)
				S_DEC: begin
					case (cmd_q.action)
						ACT_ORIGIN: begin
							pos_x_q <= '0;
							pos_y_q <= '0;
							goal_x_q <= '0;
							goal_y_q <= '0;
							inc_x_q <= '0;
							inc_y_q <= '0;
							steps_left_q <= '0;
							delay_reload_q <= '0;
							delay_count_q <= '0;
							moving_q <= 1'b0;
							cnt_q <= CNT_MUL;
						end
						ACT_TICK: begin
							if (moving_q) begin
								if (delay_count_q > 32'd1) begin
									delay_count_q <= delay_count_q - 32'd1;
								end else if (steps_left_q != '0) begin
									// next intermediate point
									steps_left_q <= steps_left_q - 1'b1;
									pos_x_q <= pos_x_q + inc_x_q[31:0];
									pos_y_q <= pos_y_q + inc_y_q[31:0];
									delay_count_q <= delay_reload_q;
									cnt_q <= CNT_MUL;
								end else begin
									// land exactly on the target
									pos_x_q <= goal_x_q;
									pos_y_q <= goal_y_q;
									delay_count_q <= '0;
									moving_q <= 1'b0;
									cnt_q <= CNT_MUL;
								end
							end
						end
						default: begin
							if (moving_q) begin
								cnt_q <= CNT_MUL;
							end else begin
								goal_x_q <= gx_c;
								goal_y_q <= gy_c;
							end
						end
					endcase
				end
				S_DELTA: cnt_q <= CNT_MUL;
				S_SQX: if (cnt_q == '0) cnt_q <= CNT_MUL;
				S_SQY: if (cnt_q == '0) cnt_q <= CNT_ROOT;
				S_CHK: begin
					if (alu_rsp.cs_ge) begin
						cnt_q <= CNT_DIV;
					end else begin
						// short move: jump straight to the target
						pos_x_q <= goal_x_q;
						pos_y_q <= goal_y_q;
						moving_q <= 1'b0;
						steps_left_q <= '0;
						delay_count_q <= '0;
						cnt_q <= CNT_MUL;
					end
				end
				S_SAT: cnt_q <= CNT_DIV;
				S_FIXX: begin
					inc_x_q <= sx_q ? (DIFF_W'(0) - quo_q) : quo_q;
					cnt_q <= CNT_DIV;
				end
				S_FIXY: begin
					inc_y_q <= sy_q ? (DIFF_W'(0) - quo_q) : quo_q;
					cnt_q <= CNT_MUL;
				end
				S_NUM: if (cnt_q == '0) cnt_q <= CNT_MUL;
				S_DSAT: if (!alu_rsp.cs_ge) cnt_q <= CNT_DLY;
				S_ARM: begin
					pos_x_q <= pos_x_q + inc_x_q[31:0];
					pos_y_q <= pos_y_q + inc_y_q[31:0];
					steps_left_q <= steps_q - 1'b1;
					delay_reload_q <= dly_c;
					delay_count_q <= dly_c;
					moving_q <= 1'b1;
					cnt_q <= CNT_MUL;
				end
				S_CVX: if (cnt_q == '0) cnt_q <= CNT_MUL;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cmd_q <= cmd;
		case (state_q)
			S_DEC: begin
				feed_q <= feed_c;
				case (cmd_q.action)
					ACT_ORIGIN: begin
						st_q <= ST_FINAL;
						busy_q <= 1'b0;
					end
					ACT_TICK: begin
						st_q <= (steps_left_q != '0) ? ST_MID : ST_FINAL;
						busy_q <= (steps_left_q != '0);
					end
					default: begin
						st_q <= ST_BUSY;
						busy_q <= 1'b1;
					end
				endcase
			end
			S_DELTA: begin
				sx_q <= dx_c[DIFF_W-1];
				sy_q <= dy_c[DIFF_W-1];
				ax_q <= dx_c[DIFF_W-1] ? (DIFF_W'(0) - dx_c) : dx_c;
				ay_q <= dy_c[DIFF_W-1] ? (DIFF_W'(0) - dy_c) : dy_c;
			end
			S_SQX: acc_q <= mac;
			S_SQY: begin
				acc_q <= mac;
				rem_q <= '0;
				quo_q <= '0;
			end
			S_SQRT: begin
				rem_q <= step_rem;
				quo_q <= {quo_q[DIFF_W-2:0], alu_rsp.cs_ge};
				acc_q <= acc_q << 2;
			end
			S_CHK: begin
				dist_q <= quo_q;
				rem_q <= '0;
				st_q <= ST_FINAL;
				busy_q <= 1'b0;
			end
			S_DSTEP, S_DINCX, S_DINCY, S_DDLY: begin
				rem_q <= step_rem;
				quo_q <= {quo_q[DIFF_W-2:0], alu_rsp.cs_ge};
			end
			S_SAT: begin
				if (quo_q > DIFF_W'(MAX_STEPS)) begin
					steps_q <= STEPS_W'(MAX_STEPS);
				end else begin
					steps_q <= quo_q[STEPS_W-1:0];
				end
				rem_q <= '0;
				quo_q <= ax_q;
			end
			S_FIXX: begin
				rem_q <= '0;
				quo_q <= ay_q;
			end
			S_NUM: begin
				acc_q <= mac;
				// split the numerator: high part as remainder, low 32 bits to shift in
				rem_q <= CS_W'(mac[ACC_W-1:32]);
				quo_q <= {mac[31:0], 1'b0};
			end
			S_DEN: acc_q <= mac;
			S_DSAT: dly_sat_q <= alu_rsp.cs_ge;
			S_ARM: begin
				st_q <= ST_MID;
				busy_q <= 1'b1;
			end
			S_CVX: acc_q <= mac;
			S_CVY: begin
				if (cnt_q != '0) dac_x_q <= dac_round(acc_q);
				acc_q <= mac;
			end
			default: ;
		endcase
		if (pt_load) begin
			pt_q.dac_x <= dac_x_q;
			pt_q.dac_y <= dac_round(acc_q);
			pt_q.status <= st_q;
			pt_q.busy_res <= busy_q;
		end
	end

	assign pt_valid = pt_valid_q;
	assign pt = pt_q;

`ifndef SYNTHESIS
	// a running line always has a pending delay of at least one tick
	a_delay_live: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> (delay_count_q != '0))
		else $error("moving with zero delay count");

	// an accepted item is decoded on the next cycle
	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == S_DEC))
		else $error("accepted item not decoded");

	// every sequenced loop has run out before the block goes idle
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q == '0))
		else $error("iteration count left over in idle");

	// a point leaving the emit state is held in the output register
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !pt_valid_q) |=> pt_valid_q)
		else $error("emit did not load output register");
`endif

endmodule

// ----- bench/testbench.sv -----
module testbench;
	import gvi_pkg::*;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic pt_valid;
	logic pt_stall;
	pt_t pt;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_wdata;

	galvo_linear_move_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt(pt),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// items waiting to be sent and points the line is expected to produce
	cmd_t cmd_pending[$];
	pt_t pts_expected[$];
	int unsigned err_cnt;

	// register copy
	longint lim_x_lo, lim_x_hi, lim_y_lo, lim_y_hi;
	longint unsigned step_cfg, scl_x, scl_y, rapid_cfg;

	// motion state copy
	longint cur_x, cur_y, goal_x, goal_y, inc_x, inc_y;
	longint unsigned steps_rem, dly_reload, dly_cnt;
	bit in_motion;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Q16.16 mm times Q16.16 codes/mm gives Q32.32, rounded half up and clamped
	function automatic logic [15:0] to_code(longint mm, longint unsigned sc);
		longint prod;
		longint unsigned p;
		prod = mm * longint'(sc);
		if (prod < 0) begin
			return 16'd0;
		end
		p = prod;
		if (p >= (64'(DAC_MAX) << 32)) begin
			return 16'(DAC_MAX);
		end
		return 16'((p + 64'h8000_0000) >> 32);
	endfunction

	function automatic pt_t make_point(longint x, longint y, logic [1:0] st, logic b);
		pt_t r;
		r.dac_x = to_code(x, scl_x);
		r.dac_y = to_code(y, scl_y);
		r.status = st;
		r.busy_res = b;
		return r;
	endfunction

	// bitwise floor square root, two bits of the radicand per pass
	function automatic longint unsigned floor_root(logic [65:0] v);
		logic [67:0] rem;
		logic [67:0] trial;
		logic [67:0] res;
		rem = '0;
		res = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = {rem[65:0], v[2*i +: 2]};
			trial = {res[65:0], 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				res = {res[66:0], 1'b1};
			end else begin
				res = {res[66:0], 1'b0};
			end
		end
		return res[63:0];
	endfunction

	function automatic longint clamp_axis(longint v, longint lo, longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic longint sext32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	task automatic apply_reg(logic [2:0] idx, logic [31:0] v);
		case (idx)
			CFG_X_MIN: lim_x_lo = sext32(v);
			CFG_X_MAX: lim_x_hi = sext32(v);
			CFG_Y_MIN: lim_y_lo = sext32(v);
			CFG_Y_MAX: lim_y_hi = sext32(v);
			CFG_STEP_LEN: step_cfg = 64'(v);
			CFG_SCALE_X: scl_x = 64'(v);
			CFG_SCALE_Y: scl_y = 64'(v);
			default: rapid_cfg = 64'(v);
		endcase
	endtask

	// work out the point (if any) that one accepted item produces
	task automatic predict_point(cmd_t c);
		longint dx, dy;
		longint unsigned ax, ay, line_len, sl, stp, fd, num, den, d;
		logic [65:0] sq;
		if (c.action == ACT_ORIGIN) begin
			cur_x = 0; cur_y = 0; goal_x = 0; goal_y = 0; inc_x = 0; inc_y = 0;
			steps_rem = 0; dly_reload = 0; dly_cnt = 0;
			in_motion = 1'b0;
			pts_expected.push_back(make_point(0, 0, ST_FINAL, 1'b0));
		end else if (c.action == ACT_TICK) begin
			if (!in_motion) begin
				// idle tick, nothing comes out
			end else if (dly_cnt > 1) begin
				dly_cnt--;
			end else if (steps_rem > 0) begin
				steps_rem--;
				cur_x += inc_x;
				cur_y += inc_y;
				dly_cnt = dly_reload;
				pts_expected.push_back(make_point(cur_x, cur_y, ST_MID, 1'b1));
			end else begin
				// last delay ran out: land exactly on the goal
				cur_x = goal_x;
				cur_y = goal_y;
				dly_cnt = 0;
				in_motion = 1'b0;
				pts_expected.push_back(make_point(cur_x, cur_y, ST_FINAL, 1'b0));
			end
		end else if (in_motion) begin
			pts_expected.push_back(make_point(cur_x, cur_y, ST_BUSY, 1'b1));
		end else begin
			goal_x = clamp_axis(sext32(c.dest_x), lim_x_lo, lim_x_hi);
			goal_y = clamp_axis(sext32(c.dest_y), lim_y_lo, lim_y_hi);
			dx = goal_x - cur_x;
			dy = goal_y - cur_y;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
			line_len = floor_root(sq);
			sl = (step_cfg != 0) ? step_cfg : 1;
			if (line_len < sl) begin
				// short move jumps straight to the goal
				cur_x = goal_x;
				cur_y = goal_y;
				in_motion = 1'b0;
				steps_rem = 0;
				dly_cnt = 0;
				pts_expected.push_back(make_point(cur_x, cur_y, ST_FINAL, 1'b0));
			end else begin
				fd = (c.action == ACT_RAPID) ? rapid_cfg : 64'(c.move_feed);
				if (fd < 64'(FEED_FLOOR)) begin
					fd = 64'(FEED_FLOOR);
				end
				stp = line_len / sl;
				if (stp < 1) begin
					stp = 1;
				end
				if (stp > MAX_STEPS) begin
					stp = 64'(MAX_STEPS);
				end
				inc_x = dx / longint'(stp);
				inc_y = dy / longint'(stp);
				num = line_len * 64'd60000000;
				den = fd * stp;
				d = num / den;
				if (d < 1) begin
					d = 1;
				end
				if (d > 64'hFFFF_FFFF) begin
					d = 64'hFFFF_FFFF;
				end
				cur_x += inc_x;
				cur_y += inc_y;
				steps_rem = stp - 1;
				dly_reload = d;
				dly_cnt = d;
				in_motion = 1'b1;
				pts_expected.push_back(make_point(cur_x, cur_y, ST_MID, 1'b1));
			end
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		err_cnt++;
	endtask

	// sender: bursts of random length with random gaps, payload held while stalled
	int unsigned burst_left;
	int unsigned gap_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				predict_point(cmd);
			end
			if (!(cmd_valid && cmd_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (cmd_pending.size() > 0) begin
					cmd <= cmd_pending.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches between none, light and heavy
	int unsigned stall_mode;
	int unsigned stall_span;
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_span = $urandom_range(20, 200);
		end
		stall_span--;
		case (stall_mode)
			0: pt_stall <= 1'b0;
			1: pt_stall <= ($urandom_range(0, 1) == 0);
			default: pt_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// checker: each point against the oldest expectation
	always @(posedge clk) begin
		pt_t want;
		if (arst_n && pt_valid && !pt_stall) begin
			if (pts_expected.size() == 0) begin
				$display("unexpected point at %0t: %0h", $time, pt);
				err_cnt++;
			end else begin
				want = pts_expected.pop_front();
				if (pt.dac_x != want.dac_x) report("dac_x", 32'(pt.dac_x), 32'(want.dac_x));
				if (pt.dac_y != want.dac_y) report("dac_y", 32'(pt.dac_y), 32'(want.dac_y));
				if (pt.status != want.status) begin
					report("status", 32'(pt.status), 32'(want.status));
				end
				if (pt.busy_res != want.busy_res) begin
					report("busy_res", 32'(pt.busy_res), 32'(want.busy_res));
				end
			end
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] a, logic [31:0] x, logic [31:0] y,
			logic [31:0] f);
		cmd_t c;
		c.action = a;
		c.dest_x = x;
		c.dest_y = y;
		c.move_feed = f;
		return c;
	endfunction

	// wait until everything sent has been answered, then let the block settle
	task automatic drain();
		while (cmd_pending.size() > 0 || cmd_valid || pts_expected.size() > 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic write_regs(logic [31:0] v[8]);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= 3'(i);
			cfg_wdata <= v[i];
			apply_reg(3'(i), v[i]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] near_val();
		return 32'($urandom_range(0, 6000)) - 32'd3000;
	endfunction

	// random register setting for the random phases
	task automatic random_regs(bit extreme);
		logic [31:0] v[8];
		int unsigned pick;
		pick = $urandom_range(0, 3);
		if (extreme || pick == 0) begin
			v[0] = 32'h8000_0000; v[1] = 32'h7FFF_FFFF;
			v[2] = 32'h8000_0000; v[3] = 32'h7FFF_FFFF;
		end else if (pick == 1) begin
			// lower x limit above upper one
			v[0] = 32'($urandom_range(0, 2000)); v[1] = -32'($urandom_range(0, 2000));
			v[2] = -32'($urandom_range(0, 2500)); v[3] = 32'($urandom_range(0, 2500));
		end else begin
			v[0] = -32'($urandom_range(0, 2500)); v[1] = 32'($urandom_range(0, 2500));
			v[2] = -32'($urandom_range(0, 2500)); v[3] = 32'($urandom_range(0, 2500));
		end
		v[4] = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(32, 256));
		v[5] = extreme ? 32'hFFFF_FFFF : $urandom();
		v[6] = extreme ? 32'd0 : $urandom();
		v[7] = $urandom_range(32'hC000_0000, 32'hFFFF_FFFF);
		write_regs(v);
	endtask

	// one move with the ticks to carry it through, now and then a busy move or abort
	task automatic random_move(ref int unsigned added);
		logic [1:0] act;
		logic [31:0] fd;
		bit wild;
		int unsigned n;
		act = ($urandom_range(0, 1) == 0) ? ACT_RAPID : ACT_FEED;
		wild = ($urandom_range(0, 15) == 0);
		fd = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(32'hC000_0000, 32'hFFFF_FFFF);
		if (wild) begin
			cmd_pending.push_back(make_cmd(act, $urandom(), $urandom(), $urandom()));
		end else begin
			cmd_pending.push_back(make_cmd(act, near_val(), near_val(), fd));
		end
		n = $urandom_range(10, 160);
		added += n + 1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 40) == 0) begin
				cmd_pending.push_back(make_cmd(2'($urandom_range(0, 1)), $urandom(),
					$urandom(), $urandom()));
			end else begin
				cmd_pending.push_back(make_cmd(ACT_TICK, $urandom(), $urandom(), $urandom()));
			end
		end
		if (wild || fd < FEED_FLOOR || $urandom_range(0, 9) == 0) begin
			cmd_pending.push_back(make_cmd(ACT_ORIGIN, $urandom(), $urandom(), $urandom()));
			added++;
		end
	endtask

	initial begin
		logic [31:0] v[8];
		int unsigned added;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		pt_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		err_cnt = 0;
		burst_left = 0;
		gap_left = 0;
		stall_span = 0;
		lim_x_lo = 0; lim_x_hi = 64'h7FFF_FFFF; lim_y_lo = 0; lim_y_hi = 64'h7FFF_FFFF;
		step_cfg = 6554; scl_x = 65536; scl_y = 65536; rapid_cfg = 393216000;
		cur_x = 0; cur_y = 0; goal_x = 0; goal_y = 0; inc_x = 0; inc_y = 0;
		steps_rem = 0; dly_reload = 0; dly_cnt = 0; in_motion = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// full-range limits, huge step so every move jumps but the corner-to-corner one, clamp-high and zero scales
		v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd393216000};
		write_regs(v);
		cmd_pending.push_back(make_cmd(ACT_RAPID, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
		cmd_pending.push_back(make_cmd(ACT_FEED, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
		cmd_pending.push_back(make_cmd(ACT_ORIGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		cmd_pending.push_back(make_cmd(ACT_TICK, 32'd0, 32'd0, 32'd0));
		cmd_pending.push_back(make_cmd(ACT_RAPID, 32'd65536, 32'd1, 32'hFFFF_FFFF));
		drain();

		// lower x limit above upper one, zero step length, rapid feed under the floor
		v = '{32'd100000, -32'd100000, -32'd65536, 32'd65536,
			32'd0, 32'h0100_0000, 32'hFFFF_FFFF, 32'd0};
		write_regs(v);
		cmd_pending.push_back(make_cmd(ACT_ORIGIN, 32'd0, 32'd0, 32'd0));
		// long line, saturates the step count
		cmd_pending.push_back(make_cmd(ACT_RAPID, -32'd5, 32'h7FFF_FFFF, 32'd0));
		cmd_pending.push_back(make_cmd(ACT_FEED, 32'd7, 32'd7, 32'd7));
		for (int i = 0; i < 3; i++) begin
			cmd_pending.push_back(make_cmd(ACT_TICK, 32'd0, 32'd0, 32'd0));
		end
		// abort in mid-line
		cmd_pending.push_back(make_cmd(ACT_ORIGIN, 32'd0, 32'd0, 32'd0));
		cmd_pending.push_back(make_cmd(ACT_FEED, 32'd100003, 32'd4, 32'hFFFF_FFFF));
		drain();
		// ticks step the running line on, one-tick delays; the feed that follows gets a busy answer
		for (int i = 0; i < 8; i++) begin
			cmd_pending.push_back(make_cmd(ACT_TICK, 32'd0, 32'd0, 32'd0));
		end
		cmd_pending.push_back(make_cmd(ACT_FEED, 32'd100000, 32'd40, 32'd100));
		for (int i = 0; i < 3; i++) begin
			cmd_pending.push_back(make_cmd(ACT_TICK, 32'd0, 32'd0, 32'd0));
		end
		cmd_pending.push_back(make_cmd(ACT_ORIGIN, 32'd0, 32'd0, 32'd0));
		drain();

		// random phases, extreme settings on the first and the last
		for (int ph = 0; ph < 6; ph++) begin
			random_regs(ph == 0 || ph == 5);
			added = 0;
			while (added < 250) begin
				random_move(added);
			end
			drain();
		end

		if (err_cnt == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	initial begin
		#64000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
